/* hw/rtl/bpra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpra_pkg
// shared types and constants of the bitmap page run allocator
// ----------------------------------------------------------------------------
package bpra_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int COUNT_W   = PAGE_W + 1;
    localparam int WORD_W    = 64;
    localparam int WADDR_W   = PAGE_W - $clog2(WORD_W);
    localparam int CHUNK_W   = 8;
    localparam int CSEL_W    = $clog2(WORD_W / CHUNK_W);

    localparam logic [COUNT_W-1:0] NUM_PAGES_C = COUNT_W'(NUM_PAGES);

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COUNT_W-1:0] run_length;
        logic [PAGE_W-1:0]  start_page;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0]  alloc_page;
        logic               out_of_memory;
        logic [COUNT_W-1:0] free_count;
    } t_out_item;

    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } t_mem_req;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] run_end;
        logic [COUNT_W-1:0] run;
    } t_scan_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN_RD,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/bpra_bitmap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpra_bitmap
// used-page bitmap, one 64-bit word per row, rows read as all used until written
// ----------------------------------------------------------------------------
module bpra_bitmap (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bpra_pkg::t_mem_req        i_req,
    output logic [bpra_pkg::WORD_W-1:0] o_rd_data
);
    import bpra_pkg::*;

    localparam int ROWS = 1 << WADDR_W;

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    // unwritten rows read back as all ones: every page used
    assign o_rd_data = r_rd_vld ? r_rd_data : '1;

endmodule

/* hw/rtl/bpra_scan_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpra_scan_step
// run tracker over one chunk of eight pages
// ----------------------------------------------------------------------------
module bpra_scan_step (
    input  logic [bpra_pkg::CHUNK_W-1:0] i_used,
    input  logic [bpra_pkg::PAGE_W-1:0]  i_base,
    input  logic [bpra_pkg::COUNT_W-1:0] i_from,
    input  logic [bpra_pkg::COUNT_W-1:0] i_lim,
    input  logic [bpra_pkg::COUNT_W-1:0] i_run,
    input  logic [bpra_pkg::COUNT_W-1:0] i_need,
    output bpra_pkg::t_scan_res          o_res
);
    import bpra_pkg::*;

    always_comb begin
        logic [COUNT_W-1:0] run;
        logic [COUNT_W-1:0] idx;
        logic [COUNT_W-1:0] run_end;
        logic               fnd;
        logic               busy;
        run     = i_run;
        run_end = '0;
        fnd     = 1'b0;
        for (int k = 0; k < CHUNK_W; k++) begin
            idx  = {1'b0, i_base} + COUNT_W'(k);
            // pages outside the scan window count as used
            busy = i_used[k] || (idx < i_from) || (idx >= i_lim);
            if (!fnd) begin
                if (busy) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                    if (run == i_need) begin
                        fnd     = 1'b1;
                        run_end = idx + 1'b1;
                    end
                end
            end
        end
        o_res.found   = fnd;
        o_res.run_end = run_end;
        o_res.run     = run;
    end

endmodule

/* hw/rtl/bitmap_page_run_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_unit
// next-fit page run allocator over a used-page bitmap
// ----------------------------------------------------------------------------
// One request at a time. An allocate scans the bitmap eight pages a cycle
// through one shared run tracker, reading a 64-page word from the bitmap
// memory before every eight chunks, first from the cursor up to the page
// limit, then from page 0 up to the old cursor. A hit then rewrites each
// touched word by read-modify-write; a free clears each touched word by
// read-modify-write. The request channel stalls until the result is loaded
// into the output register. After reset every page reads as used, with no
// clearing pass; software frees the usable ranges. The user must write
// page_limit over the configuration port only while no request is open;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bpra_pkg::t_in_item            i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bpra_pkg::t_out_item           o_out_data,
    // page_limit register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpra_pkg::COUNT_W-1:0]  i_cfg_data
);
    import bpra_pkg::*;

    // state
    t_state               r_state, n_state;
    logic                 r_func, n_func;
    logic [COUNT_W-1:0]   r_len, n_len;
    logic                 r_pass2, n_pass2;
    logic [PAGE_W-1:0]    r_base, n_base;
    logic [COUNT_W-1:0]   r_run, n_run;
    logic [COUNT_W-1:0]   r_lo, n_lo;
    logic [COUNT_W-1:0]   r_hi, n_hi;
    logic [WADDR_W-1:0]   r_wptr, n_wptr;
    logic [COUNT_W-1:0]   r_cursor, n_cursor;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [COUNT_W-1:0]   r_limit;
    logic                 r_oom, n_oom;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic                 r_out_valid;
    t_out_item            r_out;

    // datapath
    t_mem_req             mem_req;
    logic [WORD_W-1:0]    mem_rd_data;
    t_scan_res            scan;
    logic [CHUNK_W-1:0]   chunk;
    logic [COUNT_W-1:0]   eff_lim;
    logic [COUNT_W-1:0]   from_p;
    logic [COUNT_W-1:0]   lim_p;
    logic [COUNT_W-1:0]   next_base;
    logic                 pass_end;
    logic                 pass_empty;
    logic                 in_xfer;
    logic                 out_free;
    logic [WORD_W-1:0]    mark_mask;
    logic [WADDR_W-1:0]   last_word;
    logic [COUNT_W-1:0]   hi_m1;
    logic [COUNT_W:0]     free_end;
    logic [COUNT_W:0]     count_sum;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // a limit above the page store acts as the store size
    assign eff_lim = (r_limit > NUM_PAGES_C) ? NUM_PAGES_C : r_limit;

    // scan window of the current pass
    assign from_p = r_pass2 ? '0 : r_cursor;
    assign lim_p  = r_pass2 ? ((r_cursor < eff_lim) ? r_cursor : eff_lim) : eff_lim;
    assign pass_empty = (from_p >= lim_p);

    assign next_base = {1'b0, r_base} + COUNT_W'(CHUNK_W);
    assign pass_end  = (next_base >= lim_p);

    // chunk of the word under the scan position
    assign chunk = mem_rd_data[{r_base[PAGE_W-WADDR_W-1 -: CSEL_W],
                                {($clog2(CHUNK_W)){1'b0}}} +: CHUNK_W];

    // free request bounds, clipped at the end of the store
    assign free_end  = {2'b00, i_in_data.start_page} + {1'b0, i_in_data.run_length};
    assign count_sum = {1'b0, r_count} + {1'b0, i_in_data.run_length};

    assign hi_m1     = r_hi - 1'b1;
    assign last_word = hi_m1[PAGE_W-1 -: WADDR_W];

    always_comb begin
        logic [COUNT_W-1:0] idx;
        for (int j = 0; j < WORD_W; j++) begin
            idx = {1'b0, r_wptr, ($clog2(WORD_W))'(j)};
            mark_mask[j] = (idx >= r_lo) && (idx < r_hi);
        end
    end

    bpra_scan_step u_scan (
        .i_used (chunk),
        .i_base (r_base),
        .i_from (from_p),
        .i_lim  (lim_p),
        .i_run  (r_run),
        .i_need (r_len),
        .o_res  (scan)
    );

    bpra_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.func == FUNC_FREE) begin
                        n_state = (i_in_data.run_length == '0) ? ST_DONE : ST_MARK_RD;
                    end else begin
                        n_state = (i_in_data.run_length == '0) ? ST_DONE : ST_START;
                    end
                end
            end
            ST_START: begin
                if (!pass_empty) begin
                    n_state = ST_SCAN_RD;
                end else if (r_pass2) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan.found) begin
                    n_state = ST_MARK_RD;
                end else if (pass_end) begin
                    n_state = r_pass2 ? ST_DONE : ST_START;
                end else if (next_base[PAGE_W-WADDR_W-1:0] == '0) begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_MARK_RD: begin
                n_state = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                n_state = (r_wptr == last_word) ? ST_DONE : ST_MARK_RD;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        mem_req    = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_SCAN_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_base[PAGE_W-1 -: WADDR_W];
            end
            ST_MARK_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_wptr;
            end
            ST_MARK_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_wptr;
                mem_req.wr_data = (r_func == FUNC_ALLOC) ? (mem_rd_data | mark_mask)
                                                         : (mem_rd_data & ~mark_mask);
            end
            ST_START, ST_SCAN, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // datapath updates
    always_comb begin
        n_func   = r_func;
        n_len    = r_len;
        n_pass2  = r_pass2;
        n_base   = r_base;
        n_run    = r_run;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_wptr   = r_wptr;
        n_cursor = r_cursor;
        n_count  = r_count;
        n_oom    = r_oom;
        n_page   = r_page;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_func  = i_in_data.func;
                    n_len   = i_in_data.run_length;
                    n_pass2 = 1'b0;
                    n_page  = '0;
                    n_oom   = 1'b0;
                    if (i_in_data.func == FUNC_FREE) begin
                        n_lo   = {1'b0, i_in_data.start_page};
                        n_hi   = (free_end > {1'b0, NUM_PAGES_C}) ? NUM_PAGES_C
                                                                  : free_end[COUNT_W-1:0];
                        n_wptr = i_in_data.start_page[PAGE_W-1 -: WADDR_W];
                        n_count = (count_sum > {1'b0, NUM_PAGES_C}) ? NUM_PAGES_C
                                                                    : count_sum[COUNT_W-1:0];
                    end else if (i_in_data.run_length == '0) begin
                        n_oom = 1'b1;
                    end
                end
            end
            ST_START: begin
                n_run = '0;
                if (!pass_empty) begin
                    n_base = {from_p[PAGE_W-1:$clog2(CHUNK_W)], {($clog2(CHUNK_W)){1'b0}}};
                end else if (r_pass2) begin
                    n_oom = 1'b1;
                end else begin
                    n_pass2 = 1'b1;
                end
            end
            ST_SCAN: begin
                if (scan.found) begin
                    n_lo     = scan.run_end - r_len;
                    n_hi     = scan.run_end;
                    n_wptr   = n_lo[PAGE_W-1 -: WADDR_W];
                    n_page   = n_lo[PAGE_W-1:0];
                    n_cursor = scan.run_end;
                    n_count  = (r_count > r_len) ? (r_count - r_len) : '0;
                end else if (pass_end) begin
                    if (r_pass2) begin
                        n_oom = 1'b1;
                    end else begin
                        n_pass2 = 1'b1;
                    end
                end else begin
                    n_run  = scan.run;
                    n_base = next_base[PAGE_W-1:0];
                end
            end
            ST_MARK_WR: begin
                n_wptr = r_wptr + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_count     <= '0;
            r_limit     <= NUM_PAGES_C;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_count  <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_len   <= n_len;
        r_pass2 <= n_pass2;
        r_base  <= n_base;
        r_run   <= n_run;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_wptr  <= n_wptr;
        r_oom   <= n_oom;
        r_page  <= n_page;
        if (r_state == ST_DONE && out_free) begin
            r_out.alloc_page    <= r_page;
            r_out.out_of_memory <= r_oom;
            r_out.free_count    <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // a request transfer always starts work
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != ST_IDLE)
        else $error("request taken but sequencer stayed idle");

    // a failed allocation never reports a page
    a_oom_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_of_memory |-> o_out_data.alloc_page == '0)
        else $error("out of memory result carries a page");

    // the run tracker never holds a complete run
    a_run_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_run < r_len)
        else $error("run length reached request without a hit");

    // counters stay within the store
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NUM_PAGES_C && r_cursor <= NUM_PAGES_C)
        else $error("free count or cursor beyond page store");

    // bitmap is written only during a sweep
    a_write_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> $past(r_state) == ST_MARK_RD)
        else $error("bitmap write outside read-modify-write");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression bench for the bitmap page run allocator: a directed pass over the
// allocate and free corner cases, then randomised phases at several page
// limits, every result checked against a next-fit bitmap tracker in order
// ----------------------------------------------------------------------------
module tb;
    import bpra_pkg::*;

    localparam int LIMIT_CYCLES  = 4_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 1300;
    localparam int MAX_REPORTS   = 10;

    // mirror of the used-page bitmap, cursor and free count; holds the results
    // still owed by the block, oldest first
    class page_map_tracker;
        bit          used_map[NUM_PAGES];
        int unsigned cursor;
        int unsigned spare_pages;
        int unsigned page_limit;
        t_out_item   awaited_results[$];
        int unsigned mismatches;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b1;
            cursor      = 0;
            spare_pages = 0;
            page_limit  = NUM_PAGES;
            mismatches  = 0;
        endfunction

        function void set_limit(int unsigned value);
            page_limit = value;
        endfunction

        // n free pages in a row within [from, upto); claims them on a hit
        function bit claim_run(int unsigned from, int unsigned upto, int unsigned n,
                               output int unsigned first);
            int unsigned run;
            int unsigned idx;
            int unsigned k;
            run   = 0;
            first = 0;
            if (upto > NUM_PAGES) upto = NUM_PAGES;
            for (idx = from; idx < upto; idx++) begin
                if (used_map[idx]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == n) begin
                        first = idx + 1 - n;
                        for (k = first; k <= idx; k++) used_map[k] = 1'b1;
                        cursor = idx + 1;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void apply_request(t_in_item item);
            t_out_item   want;
            int unsigned len;
            int unsigned start;
            int unsigned lim;
            int unsigned old;
            int unsigned first;
            int unsigned i;
            bit          hit;
            want  = '0;
            len   = item.run_length;
            start = item.start_page;
            if (item.func == FUNC_ALLOC) begin
                lim = (page_limit > NUM_PAGES) ? NUM_PAGES : page_limit;
                old = cursor;
                hit = 1'b0;
                if (len != 0) begin
                    hit = claim_run(old, lim, len, first);
                    // wrap: second pass stops at the old cursor or the limit
                    if (!hit) hit = claim_run(0, (old < lim) ? old : lim, len, first);
                end
                if (hit) begin
                    spare_pages      = (spare_pages > len) ? spare_pages - len : 0;
                    want.alloc_page  = PAGE_W'(first);
                end else begin
                    want.out_of_memory = 1'b1;
                end
            end else begin
                // pages past the store are dropped, the count still grows by the full length, up to the store size
                for (i = 0; i < len; i++)
                    if (start + i < NUM_PAGES) used_map[start + i] = 1'b0;
                spare_pages += len;
                if (spare_pages > NUM_PAGES) spare_pages = NUM_PAGES;
            end
            want.free_count = COUNT_W'(spare_pages);
            awaited_results.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with no open request: page %0d oom %0b count %0d",
                             $time, got.alloc_page, got.out_of_memory, got.free_count);
                return;
            end
            want = awaited_results.pop_front();
            if (got.alloc_page !== want.alloc_page || got.out_of_memory !== want.out_of_memory
                    || got.free_count !== want.free_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $write("[%0t] result mismatch: expected page %0d oom %0b count %0d,",
                           $time, want.alloc_page, want.out_of_memory, want.free_count);
                    $display(" got page %0d oom %0b count %0d",
                             got.alloc_page, got.out_of_memory, got.free_count);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    t_in_item           in_data;
    logic               out_valid;
    logic               out_stall;
    t_out_item          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    // per-phase switches for random gaps on either side
    bit                 sender_idles;
    bit                 receiver_idles;
    int unsigned        cycle_count = 0;
    page_map_tracker    pages;

    bitmap_page_run_allocator_unit u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on total run length
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("bitmap_page_run_allocator_unit regression: fail");
            $finish;
        end
    end

    // one request transfer; valid is held until the block stops stalling
    task automatic send_request(input t_in_item item);
        int gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        pages.apply_request(item);
    endtask

    task automatic request(input logic func, input int len, input int start);
        t_in_item item;
        item.func       = func;
        item.run_length = COUNT_W'(len);
        item.start_page = PAGE_W'(start);
        send_request(item);
    endtask

    // hold off new requests until every owed result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pages.awaited_results.size() != 0) @(posedge clk);
    endtask

    // page_limit only changes with the block idle
    task automatic write_limit(input int value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= COUNT_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pages.set_limit(value);
    endtask

    task automatic random_phase(input int limit, input int items);
        t_in_item    item;
        int unsigned span;
        int          n;
        write_limit(limit);
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
        span = (limit > NUM_PAGES) ? NUM_PAGES : limit;
        for (n = 0; n < items; n++) begin
            item.start_page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
            if ($urandom_range(0, 99) < 45) begin
                // frees mostly land inside the managed range so allocations can hit
                item.func = FUNC_FREE;
                if (span != 0 && $urandom_range(0, 7) != 0)
                    item.start_page = PAGE_W'($urandom_range(0, span - 1));
                if ($urandom_range(0, 15) == 0)
                    item.run_length = COUNT_W'($urandom_range(0, NUM_PAGES));
                else
                    item.run_length = COUNT_W'($urandom_range(1, 32));
            end else begin
                item.func = FUNC_ALLOC;
                case ($urandom_range(0, 15))
                    0: begin
                        item.run_length = '0;
                    end
                    1: begin
                        item.run_length = COUNT_W'($urandom_range(0, NUM_PAGES));
                    end
                    default: begin
                        item.run_length = COUNT_W'($urandom_range(1, 16));
                    end
                endcase
            end
            if ($urandom_range(0, 39) == 0) drain_results();
            send_request(item);
        end
    endtask

    // result side: random stall before each transfer, checked in order
    initial begin : take_results
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = receiver_idles ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            pages.check_result(out_data);
        end
    end

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b1;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        pages          = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass, everything starts out used
        write_limit(NUM_PAGES);
        request(FUNC_ALLOC, 0, 0);              // zero length
        request(FUNC_ALLOC, 1, 4095);           // nothing free yet
        request(FUNC_FREE, NUM_PAGES, 0);       // whole store
        request(FUNC_FREE, NUM_PAGES, 4095);    // mostly past the end, count pinned at top
        request(FUNC_ALLOC, NUM_PAGES, 0);      // whole store in one run
        request(FUNC_ALLOC, 1, 0);              // cursor at the end, all used
        request(FUNC_FREE, 10, 100);
        request(FUNC_ALLOC, 10, 0);             // found on the wrap pass
        request(FUNC_FREE, 50, 0);
        request(FUNC_FREE, 8, 200);
        request(FUNC_ALLOC, 8, 0);              // next fit from the cursor
        request(FUNC_ALLOC, 50, 0);             // wraps to page 0
        request(FUNC_FREE, 20, 300);
        request(FUNC_ALLOC, 5, 0);
        request(FUNC_FREE, 5, 300);
        request(FUNC_ALLOC, 20, 0);             // free run spans the cursor, missed
        request(FUNC_FREE, 5, 310);             // pages already free
        request(FUNC_ALLOC, 15, 0);
        write_limit(0);
        request(FUNC_ALLOC, 1, 0);              // nothing managed
        write_limit((1 << COUNT_W) - 1);
        request(FUNC_ALLOC, 5, 0);              // limit above the store acts as full size
        write_limit(64);
        request(FUNC_FREE, 4, 10);
        request(FUNC_ALLOC, 4, 4095);           // cursor above the limit
        request(FUNC_FREE, 1, 4095);

        // random phases over the limit extremes and values between
        random_phase(NUM_PAGES, 50);
        random_phase((1 << COUNT_W) - 1, 50);
        random_phase(0, 20);
        random_phase(64, 50);
        random_phase($urandom_range(1, NUM_PAGES), 50);
        random_phase($urandom_range(NUM_PAGES + 1, (1 << COUNT_W) - 1), 50);
        random_phase(NUM_PAGES, 50);
        random_phase($urandom_range(1, 512), 50);
        random_phase(NUM_PAGES / 2, 50);
        random_phase(NUM_PAGES, 50);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pages.mismatches == 0 && pages.awaited_results.size() == 0)
            $display("bitmap_page_run_allocator_unit regression: pass");
        else
            $display("bitmap_page_run_allocator_unit regression: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/bpra_pkg.sv
hw/rtl/bpra_bitmap.sv
hw/rtl/bpra_scan_step.sv
hw/rtl/bitmap_page_run_allocator_unit.sv
tb/tb.sv
